/* rtl/tile_map_pixel_renderer_top_macros.svh */
// Assertion macros for the tile map pixel renderer.
`ifndef TILE_MAP_PIXEL_RENDERER_TOP_MACROS_SVH
`define TILE_MAP_PIXEL_RENDERER_TOP_MACROS_SVH

// Check that ante implies cons on every clock, off while in reset.
`define TMPR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("tile map renderer: implication failed");

// Check that cond holds on every clock, off while in reset.
`define TMPR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("tile map renderer: invariant failed");

`endif

/* rtl/tmpr_pkg.sv */
// Shared types and constants of the tile map pixel renderer.
package tmpr_pkg;

	typedef enum logic [1:0] {
		OP_MAP_WRITE   = 2'd0,
		OP_TILE_WRITE  = 2'd1,
		OP_PAL_WRITE   = 2'd2,
		OP_PIXEL_QUERY = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_WRITE_DONE  = 2'd0,
		ST_PIXEL_VALID = 2'd1,
		ST_OUTSIDE     = 2'd2
	} status_t;

	localparam logic [1:0] CFG_PIXEL_MODE  = 2'd0;
	localparam logic [1:0] CFG_MAP_WIDTH   = 2'd1;
	localparam logic [1:0] CFG_MAP_HEIGHT  = 2'd2;

	localparam int DEF_MAP_ENTRIES     = 1024;
	localparam int DEF_TILE_BYTES      = 65536;
	localparam int DEF_PALETTE_ENTRIES = 256;

	localparam int CFG_W          = 6;
	localparam int RESULT_LATENCY = 4;

endpackage

/* rtl/tile_map_pixel_renderer_top.sv */
// Tiled background renderer: map, tile and palette stores with pixel lookup.
//
//  channel   | handshake        | payload
//  ----------+------------------+---------------------------------------------
//  command   | start / busy     | opcode, write_address, write_data, pixel_x/y
//  result    | done (strobe)    | status, red, green, blue
//  config    | cfg_we           | cfg_index, cfg_wdata
//
// One transaction per clock; busy stays low. Each result strobes once its
// transaction has passed the chain map read, tile read, palette read, output
// register. Each store is written at the stage that reads it, so transactions
// keep their order without forwarding. Reset initializes the control and the
// configuration registers; the stores are not cleared.
module tile_map_pixel_renderer_top
	import tmpr_pkg::*;
#(
	parameter int MAP_ENTRIES     = DEF_MAP_ENTRIES,
	parameter int TILE_BYTES      = DEF_TILE_BYTES,
	parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       opcode,
	input  logic [15:0]      write_address,
	input  logic [15:0]      write_data,
	input  logic [7:0]       pixel_x,
	input  logic [7:0]       pixel_y,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             done,
	output logic [1:0]       status,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue
);

	localparam int MAW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
	localparam int TAW = $clog2(TILE_BYTES);
	localparam int PAW = $clog2(PALETTE_ENTRIES);

	logic             pixel_mode_q;
	logic [CFG_W-1:0] map_width_q;
	logic [CFG_W-1:0] map_height_q;

	logic [15:0] map_mem  [MAP_ENTRIES];
	logic [7:0]  tile_mem [TILE_BYTES];
	logic [14:0] pal_mem  [PALETTE_ENTRIES];

	logic        accept;
	logic [4:0]  tile_x;
	logic [4:0]  tile_y;
	logic        outside_s0;
	logic [11:0] map_idx_s0;
	logic        map_ok_s0;
	status_t     status_s0;

	logic        valid_s1;
	opcode_t     op_s1;
	status_t     status_s1;
	logic [15:0] addr_s1;
	logic [15:0] data_s1;
	logic [2:0]  cx_s1;
	logic [2:0]  cy_s1;
	logic [15:0] map_rdata_s1;

	logic [9:0]  tile_num;
	logic [2:0]  cx_f;
	logic [2:0]  cy_f;
	logic [15:0] tile_addr;
	logic        tile_ok;

	logic        valid_s2;
	opcode_t     op_s2;
	status_t     status_s2;
	logic [15:0] addr_s2;
	logic [14:0] data_s2;
	logic [3:0]  bank_s2;
	logic        nib_lo_s2;
	logic        tile_ok_s2;
	logic [7:0]  tile_rdata_s2;

	logic [7:0]  tile_byte;
	logic [3:0]  nibble;
	logic [7:0]  pal_idx;
	logic        pal_ok;

	logic        valid_s3;
	status_t     status_s3;
	logic        pal_ok_s3;
	logic [14:0] pal_rdata_s3;
	logic [14:0] color;

	logic        done_q;
	status_t     status_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q <= 1'b0;
			map_width_q  <= CFG_W'(32);
			map_height_q <= CFG_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PIXEL_MODE: pixel_mode_q <= cfg_wdata[0];
				CFG_MAP_WIDTH:  map_width_q  <= cfg_wdata;
				CFG_MAP_HEIGHT: map_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage 0: locate the map entry, read or write the map store
	assign tile_x     = pixel_x[7:3];
	assign tile_y     = pixel_y[7:3];
	assign outside_s0 = ({1'b0, tile_x} >= map_width_q) || ({1'b0, tile_y} >= map_height_q);
	assign map_idx_s0 = 12'(tile_y) * 12'(map_width_q) + 12'(tile_x);
	assign map_ok_s0  = !outside_s0 && ({1'b0, map_idx_s0} < 13'(MAP_ENTRIES));

	always_comb begin
		if (opcode != OP_PIXEL_QUERY) begin
			status_s0 = ST_WRITE_DONE;
		end else if (map_ok_s0) begin
			status_s0 = ST_PIXEL_VALID;
		end else begin
			status_s0 = ST_OUTSIDE;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == OP_MAP_WRITE
				&& ({1'b0, write_address} < 17'(MAP_ENTRIES))) begin
			map_mem[write_address[MAW-1:0]] <= write_data;
		end else if (accept && opcode == OP_PIXEL_QUERY && map_ok_s0) begin
			map_rdata_s1 <= map_mem[map_idx_s0[MAW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= opcode_t'(opcode);
		status_s1 <= status_s0;
		addr_s1   <= write_address;
		data_s1   <= write_data;
		cx_s1     <= pixel_x[2:0];
		cy_s1     <= pixel_y[2:0];
	end

	// Stage 1: apply flips, read or write the tile store
	assign tile_num  = map_rdata_s1[9:0];
	assign cx_f      = map_rdata_s1[10] ? ~cx_s1 : cx_s1;
	assign cy_f      = map_rdata_s1[11] ? ~cy_s1 : cy_s1;
	assign tile_addr = pixel_mode_q ? {tile_num, cy_f, cx_f}
		: {1'b0, tile_num, cy_f, cx_f[2:1]};
	assign tile_ok   = {1'b0, tile_addr} < 17'(TILE_BYTES);

	always_ff @(posedge clk) begin
		if (valid_s1 && op_s1 == OP_TILE_WRITE
				&& ({1'b0, addr_s1} < 17'(TILE_BYTES))) begin
			tile_mem[addr_s1[TAW-1:0]] <= data_s1[7:0];
		end else if (valid_s1 && status_s1 == ST_PIXEL_VALID && tile_ok) begin
			tile_rdata_s2 <= tile_mem[tile_addr[TAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		op_s2      <= op_s1;
		status_s2  <= status_s1;
		addr_s2    <= addr_s1;
		data_s2    <= data_s1[14:0];
		bank_s2    <= map_rdata_s1[15:12];
		nib_lo_s2  <= cx_f[0];
		tile_ok_s2 <= tile_ok;
	end

	// Stage 2: form the palette index, read or write the palette
	assign tile_byte = tile_ok_s2 ? tile_rdata_s2 : 8'd0;
	assign nibble    = nib_lo_s2 ? tile_byte[3:0] : tile_byte[7:4];
	assign pal_idx   = pixel_mode_q ? tile_byte : {bank_s2, nibble};
	assign pal_ok    = {1'b0, pal_idx} < 9'(PALETTE_ENTRIES);

	always_ff @(posedge clk) begin
		if (valid_s2 && op_s2 == OP_PAL_WRITE
				&& ({1'b0, addr_s2} < 17'(PALETTE_ENTRIES))) begin
			pal_mem[addr_s2[PAW-1:0]] <= data_s2;
		end else if (valid_s2 && status_s2 == ST_PIXEL_VALID && pal_ok) begin
			pal_rdata_s3 <= pal_mem[pal_idx[PAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		status_s3 <= status_s2;
		pal_ok_s3 <= pal_ok;
	end

	// Stage 3: expand the color into the output register
	assign color = (status_s3 == ST_PIXEL_VALID && pal_ok_s3) ? pal_rdata_s3 : 15'd0;

	always_ff @(posedge clk) begin
		status_q <= status_s3;
		red_q    <= {color[4:0], 3'b000};
		green_q  <= {color[9:5], 3'b000};
		blue_q   <= {color[14:10], 3'b000};
	end

	assign done   = done_q;
	assign status = status_q;
	assign red    = red_q;
	assign green  = green_q;
	assign blue   = blue_q;

endmodule

/* rtl/tmpr_checker.sv */
// Port-level assertions for the tile map pixel renderer and their binding.
`include "tile_map_pixel_renderer_top_macros.svh"

module tmpr_checker
	import tmpr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] opcode,
	input logic       done,
	input logic [1:0] status,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	logic wr_op;
	logic status_wr;
	logic rgb_zero;

	assign wr_op     = (opcode != OP_PIXEL_QUERY);
	assign status_wr = (status == ST_WRITE_DONE);
	assign rgb_zero  = (red == 8'd0) && (green == 8'd0) && (blue == 8'd0);

	`TMPR_ASSERT_IMPLY(a_done_follows, clk, arst_n, start && !busy, ##RESULT_LATENCY done)
	`TMPR_ASSERT_IMPLY(a_no_spurious, clk, arst_n, done, $past(start && !busy, RESULT_LATENCY))
	`TMPR_ASSERT_IMPLY(a_status_kind, clk, arst_n, done, status_wr == $past(wr_op, RESULT_LATENCY))
	`TMPR_ASSERT_IMPLY(a_zero_color, clk, arst_n, done && status != ST_PIXEL_VALID, rgb_zero)

endmodule

bind tile_map_pixel_renderer_top tmpr_checker u_tmpr_checker (.*);
